// ----- design/lzwc_pkg.sv -----
// shared types, sizes and tree geometry for the lzw byte compressor
// no dependencies; every other file of the block imports this package
package lzwc_pkg;

  // dictionary size and code widths
  localparam int DICT_ENTRIES = 4096;
  localparam int FIRST_FREE   = 256;
  localparam int SYM_W        = 8;
  localparam int CODE_W       = 12;
  localparam int IDX_W        = $clog2(DICT_ENTRIES);
  localparam int CNT_W        = IDX_W + 1;
  localparam int S_DATA_W     = 8;
  localparam int M_DATA_W     = 16;

  // match tree: each node merges FAN children, one register per level
  localparam int FAN_W      = 4;
  localparam int FAN        = 1 << FAN_W;
  localparam int LEVELS     = (IDX_W + FAN_W - 1) / FAN_W;
  localparam int PAD_W      = LEVELS * FAN_W;
  localparam int PAD_LEAVES = 1 << PAD_W;

  // nodes in tree level l (level 1 sits right above the cells)
  function automatic int lvl_nodes(input int l);
    return 1 << (PAD_W - l * FAN_W);
  endfunction

  // first slot of tree level l in the flat node array
  function automatic int lvl_off(input int l);
    int s;
    s = 0;
    for (int j = 1; j < l; j++) begin
      s = s + lvl_nodes(j);
    end
    return s;
  endfunction

  localparam int TREE_NODES = lvl_off(LEVELS + 1);

  // search lasts through the cell compare and every tree level
  localparam int SRCH_W = $clog2(LEVELS + 1);

  // key presented to every cell
  typedef struct packed {
    logic [IDX_W-1:0] prefix;
    logic [SYM_W-1:0] sym;
  } key_t;

  // dictionary insert, broadcast to every cell
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    logic [IDX_W-1:0] prefix;
    logic [SYM_W-1:0] sym;
  } wr_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DECIDE,
    ST_LAST
  } state_t;

endpackage

// ----- design/lzwc_cell.sv -----
// one dictionary entry: stores prefix code and byte, compares against the key
// depends on lzwc_pkg
module lzwc_cell (
  input  logic                      clk,
  input  logic [lzwc_pkg::IDX_W-1:0] cell_idx,
  input  lzwc_pkg::wr_t             wr,
  input  lzwc_pkg::key_t            key,
  input  logic [lzwc_pkg::CNT_W-1:0] nfc,
  output logic                      hit
);
  import lzwc_pkg::*;

  logic [IDX_W-1:0] prefix;
  logic [SYM_W-1:0] sym;
  logic             live;

  // entry is in use when its code is below the next free code
  assign live = ({1'b0, cell_idx} < nfc);

  // store the entry when the insert targets this cell
  always_ff @(posedge clk) begin
    if (wr.en && (wr.addr == cell_idx)) begin
      prefix <= wr.prefix;
      sym    <= wr.sym;
    end
  end

  // registered compare, handed to the first tree level
  always_ff @(posedge clk) begin
    hit <= live && (prefix == key.prefix) && (sym == key.sym);
  end

endmodule

// ----- design/lzwc_match_tree.sv -----
// registered reduction of the cell hit bits into one hit flag and its code
// at most one cell hits, so each node ors the codes of its children
// depends on lzwc_pkg
module lzwc_match_tree (
  input  logic                            clk,
  input  logic [lzwc_pkg::PAD_LEAVES-1:0] leaf_hit,
  output logic                            hit,
  output logic [lzwc_pkg::IDX_W-1:0]      idx
);
  import lzwc_pkg::*;

  logic             node_hit      [TREE_NODES];
  logic [PAD_W-1:0] node_idx      [TREE_NODES];
  logic             node_hit_next [TREE_NODES];
  logic [PAD_W-1:0] node_idx_next [TREE_NODES];

  // merge FAN children per node, level by level
  always_comb begin
    logic             h;
    logic [PAD_W-1:0] x;
    logic             ch;
    logic [PAD_W-1:0] ci;
    for (int l = 1; l <= LEVELS; l++) begin
      for (int n = 0; n < lvl_nodes(l); n++) begin
        h = 1'b0;
        x = '0;
        for (int c = 0; c < FAN; c++) begin
          if (l == 1) begin
            ch = leaf_hit[n * FAN + c];
            ci = '0;
          end else begin
            ch = node_hit[lvl_off(l - 1) + n * FAN + c];
            ci = node_idx[lvl_off(l - 1) + n * FAN + c];
          end
          if (ch) begin
            x = x | ci | (PAD_W'(c) << ((l - 1) * FAN_W));
          end
          h = h | ch;
        end
        node_hit_next[lvl_off(l) + n] = h;
        node_idx_next[lvl_off(l) + n] = x;
      end
    end
  end

  // one register stage per level
  always_ff @(posedge clk) begin
    for (int k = 0; k < TREE_NODES; k++) begin
      node_hit[k] <= node_hit_next[k];
      node_idx[k] <= node_idx_next[k];
    end
  end

  assign hit = node_hit[lvl_off(LEVELS)];
  assign idx = node_idx[lvl_off(LEVELS)][IDX_W-1:0];

endmodule

// ----- design/lzw_byte_compressor.sv -----
// lzw byte compressor top level: sequencer, cell row and match tree
// depends on lzwc_pkg, lzwc_cell, lzwc_match_tree
//
// channel  dir  payload                                    end flag
// s_       in   tdata[7:0] symbol                          tlast = final_req
// m_       out  tdata[11:0] code, [15:12] zero             tlast = end_mark
//
// a byte extending a held match waits in search while the cells compare and the hit
// code climbs a registered tree of fan-in 16 (three levels at 4096 entries), then
// is resolved in decide; bytes enter only in idle. a stream's first byte becomes
// the match, a final byte also passes the last state. rst clears the match and the
// fill count; dictionary contents are not cleared. a stalled output holds the
// sequencer in its emitting state, with one result buffered in the output register.
module lzw_byte_compressor (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [lzwc_pkg::S_DATA_W-1:0]  s_tdata,   // [7:0] symbol
  input  logic                           s_tlast,   // final_req
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [lzwc_pkg::M_DATA_W-1:0]  m_tdata,   // [11:0] code, [15:12] zero
  output logic                           m_tlast    // end_mark
);
  import lzwc_pkg::*;

  state_t            state, state_next;
  logic [SRCH_W-1:0] cnt, cnt_next;
  logic [SYM_W-1:0]  sym_q, sym_q_next;
  logic              fin_q, fin_q_next;
  logic [IDX_W-1:0]  match_code, match_code_next;
  logic              match_valid, match_valid_next;
  logic [CNT_W-1:0]  nfc, nfc_next;
  logic              out_valid, out_valid_next;
  logic [CODE_W-1:0] out_code, out_code_next;
  logic              out_last, out_last_next;

  logic                  in_beat;
  logic                  out_free;
  wr_t                   wr;
  key_t                  key;
  logic [PAD_LEAVES-1:0] leaf_hit;
  logic                  tree_hit;
  logic [IDX_W-1:0]      tree_idx;

  assign s_tready = (state == ST_IDLE);
  assign in_beat  = s_tvalid && s_tready;
  assign out_free = !out_valid || m_tready;

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(M_DATA_W - CODE_W){1'b0}}, out_code};
  assign m_tlast  = out_last;

  assign key.prefix = match_code;
  assign key.sym    = sym_q;

  // row of dictionary cells; codes below FIRST_FREE and padding never hit
  for (genvar k = 0; k < PAD_LEAVES; k++) begin : g_row
    if (k >= FIRST_FREE && k < DICT_ENTRIES) begin : g_cell
      lzwc_cell u_cell (
        .clk      (clk),
        .cell_idx (IDX_W'(k)),
        .wr       (wr),
        .key      (key),
        .nfc      (nfc),
        .hit      (leaf_hit[k])
      );
    end else begin : g_none
      assign leaf_hit[k] = 1'b0;
    end
  end

  lzwc_match_tree u_tree (
    .clk      (clk),
    .leaf_hit (leaf_hit),
    .hit      (tree_hit),
    .idx      (tree_idx)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      cnt         <= '0;
      match_code  <= '0;
      match_valid <= 1'b0;
      nfc         <= CNT_W'(FIRST_FREE);
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      cnt         <= cnt_next;
      match_code  <= match_code_next;
      match_valid <= match_valid_next;
      nfc         <= nfc_next;
      out_valid   <= out_valid_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    sym_q    <= sym_q_next;
    fin_q    <= fin_q_next;
    out_code <= out_code_next;
    out_last <= out_last_next;
  end

  // sequencer: next state, dictionary insert and output loading
  always_comb begin
    state_next       = state;
    cnt_next         = cnt;
    sym_q_next       = sym_q;
    fin_q_next       = fin_q;
    match_code_next  = match_code;
    match_valid_next = match_valid;
    nfc_next         = nfc;
    out_valid_next   = out_valid && !m_tready;
    out_code_next    = out_code;
    out_last_next    = out_last;
    wr.en            = 1'b0;
    wr.addr          = nfc[IDX_W-1:0];
    wr.prefix        = match_code;
    wr.sym           = sym_q;

    case (state)
      ST_IDLE: begin
        if (in_beat) begin
          sym_q_next = s_tdata[SYM_W-1:0];
          fin_q_next = s_tlast;
          cnt_next   = '0;
          if (match_valid) begin
            state_next = ST_SEARCH;
          end else begin
            // first byte of a stream just becomes the match
            match_code_next  = IDX_W'(s_tdata[SYM_W-1:0]);
            match_valid_next = 1'b1;
            if (s_tlast) begin
              state_next = ST_LAST;
            end
          end
        end
      end

      ST_SEARCH: begin
        cnt_next = cnt + 1'b1;
        if (cnt == SRCH_W'(LEVELS)) begin
          state_next = ST_DECIDE;
        end
      end

      ST_DECIDE: begin
        if (tree_hit) begin
          match_code_next = tree_idx;
          state_next      = fin_q ? ST_LAST : ST_IDLE;
        end else if (out_free) begin
          // emit the match, add the extension while there is room
          out_valid_next  = 1'b1;
          out_code_next   = CODE_W'(match_code);
          out_last_next   = 1'b0;
          wr.en           = (nfc < CNT_W'(DICT_ENTRIES));
          if (wr.en) begin
            nfc_next = nfc + 1'b1;
          end
          match_code_next = IDX_W'(sym_q);
          state_next      = fin_q ? ST_LAST : ST_IDLE;
        end
      end

      ST_LAST: begin
        if (out_free) begin
          // close the stream and restart the dictionary
          out_valid_next   = 1'b1;
          out_code_next    = CODE_W'(match_code);
          out_last_next    = 1'b1;
          match_valid_next = 1'b0;
          match_code_next  = '0;
          nfc_next         = CNT_W'(FIRST_FREE);
          state_next       = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule
